/* rtl/wlcs_pkg.sv */
// Package for the word-length Caesar shifter: sequencer state type, alphabet
// constants and small character helper functions.
// No dependencies.
`default_nettype none

package wlcs_pkg;

   // Default word store depth; the top level's parameter takes it.
   localparam int MAX_WORD_DEFAULT = 32;

   // Counts handled by the shift helper never exceed this many bits.
   localparam int COUNT_MAX_W = 6;

   localparam int CHAR_W  = 8;
   localparam int SHIFT_W = 5;

   localparam logic [CHAR_W-1:0] UPPER_BASE = 8'h41;
   localparam logic [CHAR_W-1:0] UPPER_LAST = 8'h5A;
   localparam logic [CHAR_W-1:0] LOWER_BASE = 8'h61;
   localparam logic [CHAR_W-1:0] LOWER_LAST = 8'h7A;
   localparam int                ALPHA_LEN  = 26;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT,
      ST_BYTE
   } seq_state_type;

   function automatic logic is_upper(input logic [CHAR_W-1:0] c);
      return (c >= UPPER_BASE) && (c <= UPPER_LAST);
   endfunction

   function automatic logic is_lower(input logic [CHAR_W-1:0] c);
      return (c >= LOWER_BASE) && (c <= LOWER_LAST);
   endfunction

   // Word length modulo the alphabet size, for lengths below three alphabets.
   function automatic logic [SHIFT_W-1:0] shift_of(input logic [COUNT_MAX_W-1:0] n);
      logic [COUNT_MAX_W-1:0] r;
      if (n >= COUNT_MAX_W'(2 * ALPHA_LEN)) begin
         r = n - COUNT_MAX_W'(2 * ALPHA_LEN);
      end else if (n >= COUNT_MAX_W'(ALPHA_LEN)) begin
         r = n - COUNT_MAX_W'(ALPHA_LEN);
      end else begin
         r = n;
      end
      return r[SHIFT_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/wlcs_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module wlcs_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/wlcs_rotate.sv */
// Shared letter rotation unit: one subtract, one add and one compare-subtract.
// Depends on wlcs_pkg.
`default_nettype none

module wlcs_rotate (
   input  wire logic [wlcs_pkg::CHAR_W-1:0]  char_in,
   input  wire logic [wlcs_pkg::SHIFT_W-1:0] shift,
   output logic      [wlcs_pkg::CHAR_W-1:0]  char_out
);

   logic [wlcs_pkg::CHAR_W-1:0] base;
   logic [wlcs_pkg::CHAR_W-1:0] offset;
   logic [5:0]                  sum;
   logic [5:0]                  wrapped;
   logic                        letter;

   always_comb begin
      letter = 1'b1;
      if (wlcs_pkg::is_lower(char_in)) begin
         base = wlcs_pkg::LOWER_BASE;
      end else if (wlcs_pkg::is_upper(char_in)) begin
         base = wlcs_pkg::UPPER_BASE;
      end else begin
         base   = '0;
         letter = 1'b0;
      end
      offset  = char_in - base;
      sum     = 6'(offset[4:0]) + 6'(shift);
      wrapped = (sum >= 6'(wlcs_pkg::ALPHA_LEN)) ? sum - 6'(wlcs_pkg::ALPHA_LEN) : sum;
      char_out = letter ? base + wlcs_pkg::CHAR_W'(wrapped) : char_in;
   end

endmodule

`default_nettype wire

/* rtl/word_length_caesar_shift.sv */
// Top level of the word-length Caesar shifter: sequencer, word store and
// output register. Depends on wlcs_pkg, wlcs_ram and wlcs_rotate.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  req_char_in, req_end_of_text
//   rsp_      out        rsp_valid/rsp_ready  rsp_char_out, rsp_last_of_run,
//                                             rsp_word_overflow
//
// A letter that does not end the text is accepted and, while the store has room, stored.
// A transaction that releases a word steps the sequencer through a read state and
// an emit state for each letter, plus a byte state for a trailing non-letter byte:
// the read state does the registered read of the word store and the emit state has
// the shared rotation unit load the output register.
// Reset clears the sequencer, the letter count, the overflow flag and the
// output valid; the word store itself is not cleared.
// A stalled result channel holds the sequencer in its emit or byte state;
// req_ready is high only while the sequencer is idle.
`default_nettype none

module word_length_caesar_shift #(
   parameter int MAX_WORD = wlcs_pkg::MAX_WORD_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_end_of_text,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [7:0] rsp_char_out,
   output logic            rsp_last_of_run,
   output logic            rsp_word_overflow
);

   // The count must be able to hold MAX_WORD itself; addresses only the depth.
   localparam int CW = $clog2(MAX_WORD + 1);
   localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

   // Sequencer and word state.
   wlcs_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;         // letters buffered for the current word
   logic          ovf_ff, ovf_in;             // a letter of the current word was dropped
   logic [CW-1:0] len_ff, len_in;             // length of the word being released
   logic [CW-1:0] idx_ff, idx_in;             // next letter of the release
   logic [wlcs_pkg::SHIFT_W-1:0] shift_ff, shift_in;
   logic          rel_ovf_ff, rel_ovf_in;     // overflow flag of the word being released
   logic [7:0]    byte_ff, byte_in;           // non-letter byte that follows the word
   logic          has_byte_ff, has_byte_in;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   // Handshake and datapath helpers.
   logic          accept;
   logic          letter;
   logic          release_word;
   logic          room;
   logic [CW-1:0] count_after;
   logic          out_free;
   logic          last_letter;
   logic          ram_wr_en;
   logic          ram_rd_en;
   logic          load_letter;
   logic          load_byte;
   logic [7:0]    ram_rd_data;
   logic [7:0]    rotated;

   assign letter       = wlcs_pkg::is_upper(req_char_in) || wlcs_pkg::is_lower(req_char_in);
   assign accept       = req_valid && req_ready;
   assign release_word = !letter || req_end_of_text;
   assign room         = count_ff < CW'(MAX_WORD);
   assign count_after  = (letter && room) ? count_ff + CW'(1) : count_ff;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign last_letter  = (idx_ff + CW'(1)) == len_ff;

   wlcs_ram #(
      .WIDTH (8),
      .DEPTH (MAX_WORD)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_char_in),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   wlcs_rotate u_rotate (
      .char_in  (ram_rd_data),
      .shift    (shift_ff),
      .char_out (rotated)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wlcs_pkg::ST_IDLE: begin
            if (accept && release_word) begin
               if (count_after != '0) begin
                  state_in = wlcs_pkg::ST_READ;
               end else if (!letter) begin
                  state_in = wlcs_pkg::ST_BYTE;
               end
            end
         end
         wlcs_pkg::ST_READ: begin
            state_in = wlcs_pkg::ST_EMIT;
         end
         wlcs_pkg::ST_EMIT: begin
            if (out_free) begin
               if (!last_letter) begin
                  state_in = wlcs_pkg::ST_READ;
               end else if (has_byte_ff) begin
                  state_in = wlcs_pkg::ST_BYTE;
               end else begin
                  state_in = wlcs_pkg::ST_IDLE;
               end
            end
         end
         wlcs_pkg::ST_BYTE: begin
            if (out_free) begin
               state_in = wlcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wlcs_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready   = 1'b0;
      ram_rd_en   = 1'b0;
      load_letter = 1'b0;
      load_byte   = 1'b0;
      unique case (state_ff)
         wlcs_pkg::ST_IDLE: req_ready   = 1'b1;
         wlcs_pkg::ST_READ: ram_rd_en   = 1'b1;
         wlcs_pkg::ST_EMIT: load_letter = out_free;
         wlcs_pkg::ST_BYTE: load_byte   = out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign ram_wr_en = accept && letter && room;

   // Datapath next values.
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      shift_in     = shift_ff;
      rel_ovf_in   = rel_ovf_ff;
      byte_in      = byte_ff;
      has_byte_in  = has_byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (accept) begin
         if (release_word) begin
            // The word leaves the buffer; its length and flag travel with the release.
            count_in    = '0;
            ovf_in      = 1'b0;
            len_in      = count_after;
            idx_in      = '0;
            shift_in    = wlcs_pkg::shift_of(wlcs_pkg::COUNT_MAX_W'(count_after));
            rel_ovf_in  = ovf_ff || (letter && !room);
            byte_in     = req_char_in;
            has_byte_in = !letter;
         end else begin
            count_in = count_after;
            ovf_in   = ovf_ff || !room;
         end
      end

      if (load_letter) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = rotated;
         rsp_last_in  = last_letter && !has_byte_ff;
         rsp_ovf_in   = rel_ovf_ff;
         idx_in       = idx_ff + CW'(1);
      end

      if (load_byte) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = byte_ff;
         rsp_last_in  = 1'b1;
         rsp_ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wlcs_pkg::ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      shift_ff    <= shift_in;
      rel_ovf_ff  <= rel_ovf_in;
      byte_ff     <= byte_in;
      has_byte_ff <= has_byte_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_out      = rsp_char_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_word_overflow = rsp_ovf_ff;

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for word_length_caesar_shift: predicts every result transaction
// from the accepted text bytes and compares all fields in order.
// Depends on wlcs_pkg and the word_length_caesar_shift RTL.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = wlcs_pkg::MAX_WORD_DEFAULT;
   localparam int DRAIN_LIMIT = 200000;
   // A released word of a full store plus its trailing byte passes through a read
   // and an emit state per letter and a byte state; this settle time leaves ample margin.
   localparam int SETTLE_CYCLES = 100;

   // One expected result transaction.
   typedef struct {
      logic [7:0] ch;
      logic       last;
      logic       ovf;
   } cipher_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_in = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_char_out;
   logic       rsp_last_of_run;
   logic       rsp_word_overflow;

   // Predictor state: the letters of the word being collected, their count
   // and whether any letter of this word has been thrown away.
   logic [7:0]      word_buf [STORE_DEPTH];
   int              word_len = 0;
   logic            word_dropped = 1'b0;
   cipher_char_type cipher_queue [$];
   cipher_char_type due;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int items_sent = 0;
   int results_seen = 0;
   int words_released = 0;
   int overflow_words = 0;
   int error_count = 0;

   word_length_caesar_shift #(.MAX_WORD(STORE_DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_char_out      (rsp_char_out),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_word_overflow (rsp_word_overflow)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A hard stop in case the block hangs on either channel.
   initial begin
      #5ms;
      $display("Timed out with %0d results still outstanding", cipher_queue.size());
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   function automatic logic is_letter(input logic [7:0] ch);
      return wlcs_pkg::is_upper(ch) || wlcs_pkg::is_lower(ch);
   endfunction

   // Rotates a letter forward within its own case by the given amount.
   function automatic logic [7:0] rotate_letter(input logic [7:0] ch, input int shift);
      logic [7:0] base;
      base = (ch >= wlcs_pkg::LOWER_BASE) ? wlcs_pkg::LOWER_BASE : wlcs_pkg::UPPER_BASE;
      return base + 8'((int'(ch - base) + shift) % wlcs_pkg::ALPHA_LEN);
   endfunction

   // Works out the result transactions that one accepted text byte causes
   // and queues them in the order the block must produce them.
   function automatic void encipher_byte(input logic [7:0] ch, input logic eot);
      logic            alpha;
      int              shift;
      cipher_char_type r;
      alpha = is_letter(ch);
      if (alpha) begin
         if (word_len < STORE_DEPTH) begin
            word_buf[word_len] = ch;
            word_len++;
         end else begin
            word_dropped = 1'b1;
         end
      end
      if (!alpha || eot) begin
         shift = word_len % wlcs_pkg::ALPHA_LEN;
         for (int i = 0; i < word_len; i++) begin
            r.ch   = rotate_letter(word_buf[i], shift);
            r.last = alpha && (i == word_len - 1);
            r.ovf  = word_dropped;
            cipher_queue.push_back(r);
         end
         if (word_len > 0) begin
            words_released++;
            if (word_dropped) begin
               overflow_words++;
            end
         end
         word_len = 0;
         word_dropped = 1'b0;
         if (!alpha) begin
            r.ch   = ch;
            r.last = 1'b1;
            r.ovf  = 1'b0;
            cipher_queue.push_back(r);
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
   endfunction

   // The ready line is redrawn at every falling edge; with a zero stall
   // percentage it simply stays high.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Every result transaction is taken at the rising edge and compared field
   // by field with the oldest outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (cipher_queue.size() == 0) begin
            note_error($sformatf("unexpected result char=%02h last=%b ovf=%b",
                                 rsp_char_out, rsp_last_of_run, rsp_word_overflow));
         end else begin
            due = cipher_queue.pop_front();
            if (rsp_char_out !== due.ch || rsp_last_of_run !== due.last ||
                rsp_word_overflow !== due.ovf) begin
               note_error($sformatf(
                  "expected char=%02h last=%b ovf=%b, got char=%02h last=%b ovf=%b",
                  due.ch, due.last, due.ovf,
                  rsp_char_out, rsp_last_of_run, rsp_word_overflow));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Offers one text byte, with random idle cycles before it, and waits for
   // the transaction to be accepted. Inputs only change at falling edges.
   task automatic send_byte(input logic [7:0] ch, input logic eot);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_char_in     = ch;
      req_end_of_text = eot;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      encipher_byte(ch, eot);
      items_sent++;
   endtask

   function automatic logic [7:0] random_letter();
      logic [7:0] offset;
      offset = 8'($urandom_range(wlcs_pkg::ALPHA_LEN - 1));
      return ($urandom_range(1) != 0 ? wlcs_pkg::LOWER_BASE : wlcs_pkg::UPPER_BASE) + offset;
   endfunction

   function automatic logic [7:0] random_non_letter();
      logic [7:0] ch;
      ch = 8'($urandom_range(255));
      while (is_letter(ch)) begin
         ch = 8'($urandom_range(255));
      end
      return ch;
   endfunction

   // Sends a word of random letters; the last letter may carry end of text.
   task automatic send_word(input int len, input logic eot_on_last);
      for (int i = 0; i < len; i++) begin
         send_byte(random_letter(), eot_on_last && (i == len - 1));
      end
   endtask

   // Bytes either side of both alphabets, the two extremes and bytes with
   // the top bit set must all pass straight through.
   task automatic test_pass_through();
      send_byte(8'h00, 1'b0);
      send_byte(wlcs_pkg::UPPER_BASE - 8'd1, 1'b0);
      send_byte(wlcs_pkg::UPPER_LAST + 8'd1, 1'b0);
      send_byte(wlcs_pkg::LOWER_BASE - 8'd1, 1'b0);
      send_byte(wlcs_pkg::LOWER_LAST + 8'd1, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hC1, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // The first and last letter of each case, so that the wrap from the end
   // of the alphabet back to its start is seen in both.
   task automatic test_letter_edges();
      send_byte(wlcs_pkg::UPPER_BASE, 1'b0);
      send_byte(wlcs_pkg::UPPER_LAST, 1'b0);
      send_byte(wlcs_pkg::LOWER_BASE, 1'b0);
      send_byte(wlcs_pkg::LOWER_LAST, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(wlcs_pkg::LOWER_LAST, 1'b0);
      send_byte(wlcs_pkg::UPPER_LAST, 1'b0);
      send_byte(8'h2E, 1'b0);
   endtask

   // End of text on a letter (no byte follows), on a non-letter after a
   // word, and on a non-letter with nothing collected.
   task automatic test_end_of_text();
      send_byte(wlcs_pkg::LOWER_LAST, 1'b1);
      send_byte(wlcs_pkg::UPPER_BASE + 8'd7, 1'b0);
      send_byte(wlcs_pkg::LOWER_BASE + 8'd8, 1'b0);
      send_byte(8'h0A, 1'b1);
      send_byte(8'h21, 1'b1);
      send_byte(wlcs_pkg::UPPER_LAST, 1'b0);
      send_byte(wlcs_pkg::UPPER_LAST, 1'b1);
   endtask

   // Word lengths that matter: a shift of zero, one either side of it, a
   // store filled exactly, and stores that overflow by one and by several.
   task automatic test_word_lengths();
      send_word(26, 1'b0);
      send_byte(random_non_letter(), 1'b0);
      send_word(25, 1'b0);
      send_byte(random_non_letter(), 1'b0);
      send_word(27, 1'b1);
      send_word(STORE_DEPTH, 1'b0);
      send_byte(random_non_letter(), 1'b0);
      send_word(STORE_DEPTH + 1, 1'b1);
      send_word(STORE_DEPTH + 8, 1'b0);
      send_byte(random_non_letter(), 1'b1);
   endtask

   // Mostly well-formed words of random length and content, each closed by
   // a non-letter or by end of text on its last letter, mixed with bytes of
   // any value.
   task automatic test_random_text(input int idle_pct, input int stall_pct, input int count);
      int target;
      int pick;
      int len;
      logic eot_letter;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            send_byte(8'($urandom_range(255)), $urandom_range(4) == 0);
         end else begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               len = $urandom_range(7, 1);
            end else if (pick < 80) begin
               len = 0;
            end else if (pick < 88) begin
               len = $urandom_range(28, 24);
            end else begin
               len = $urandom_range(STORE_DEPTH + 4, STORE_DEPTH - 2);
            end
            eot_letter = (len > 0) && ($urandom_range(6) == 0);
            send_word(len, eot_letter);
            if (!eot_letter) begin
               send_byte(random_non_letter(), $urandom_range(4) == 0);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence of tests
   // ---------------------------------------------------------------------

   initial begin
      int waited;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_pass_through();
      test_letter_edges();
      test_end_of_text();

      // Random traffic in four idling phases: none, a sluggish sender, a
      // sluggish receiver and occasional idling on both sides.
      test_word_lengths();
      test_random_text(0, 0, 15);
      test_random_text(76, 0, 15);
      test_random_text(0, 76, 15);
      test_random_text(6, 6, 15);

      // Close the text so that no word is left in the store.
      send_byte(8'h2E, 1'b1);
      @(negedge clock);
      req_valid = 1'b0;

      waited = 0;
      while (cipher_queue.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (cipher_queue.size() > 0) begin
         note_error($sformatf("%0d results never arrived", cipher_queue.size()));
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d text bytes and checked %0d results.", items_sent, results_seen);
      $display("Released %0d words, %0d of them with letters lost to a full store; %0d errors.",
               words_released, overflow_words, error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
rtl/wlcs_pkg.sv
rtl/wlcs_ram.sv
rtl/wlcs_rotate.sv
rtl/word_length_caesar_shift.sv
bench/tb.sv
